[hdl/irt_pkg.sv]
// Shared types and constants for the infrared thermometer bus read block.
// No dependencies; every other file in hdl/ imports this package.
package irt_pkg;

    // Bus sequencer phases, one-hot
    typedef enum logic [18:0] {
        PH_IDLE      = 19'h00001,
        PH_START_HI  = 19'h00002,
        PH_START_LO  = 19'h00004,
        PH_WADDR_LO  = 19'h00008,
        PH_WADDR_HI  = 19'h00010,
        PH_WREG_LO   = 19'h00020,
        PH_WREG_HI   = 19'h00040,
        PH_RS_LO     = 19'h00080,
        PH_RS_HI     = 19'h00100,
        PH_RS_FALL   = 19'h00200,
        PH_RADDR_LO  = 19'h00400,
        PH_RADDR_HI  = 19'h00800,
        PH_RDLOW_LO  = 19'h01000,
        PH_RDLOW_HI  = 19'h02000,
        PH_RDHIGH_LO = 19'h04000,
        PH_RDHIGH_HI = 19'h08000,
        PH_STOP_LO   = 19'h10000,
        PH_STOP_HI   = 19'h20000,
        PH_STOP_REL  = 19'h40000
    } t_phase;

    // Configuration register indexes
    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_TICKS    = 1'b1;

    // Bits in a byte, and the read/write flag in the address byte
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic       RW_WRITE      = 1'b0;
    localparam logic       RW_READ       = 1'b1;

    // Kelvin offset in hundredths: temp = raw*2 - 27315
    localparam logic [17:0] TEMP_OFFSET = 18'd27315;

    // Result of one tick, before the output register
    typedef struct packed {
        logic        scl;
        logic        sda;
        logic        busy;
        logic        done;
        logic [15:0] raw;
    } t_result;

endpackage

[hdl/ir_thermometer_smbus_read.sv]
// Top level of the infrared thermometer bus read block.
// Depends on irt_pkg, irt_seq and irt_outreg.
//
// Each input beat is one timing tick (or a begin command) of a pin-level bus
// master that reads one 16-bit sensor register and returns the raw word and the
// temperature in hundredths of a degree Celsius. Every input beat yields exactly
// one result beat carrying the pin levels, busy/done flags and the last word.
// Throughput is one beat per clock unless the result stalls; the result is
// registered. The input is accepted whenever the result register is empty or
// is being taken in the same cycle. Configuration (index 0: 7-bit device
// address, index 1: ticks per slot, with zero treated as one) must be written
// only while the block is idle (not enforced by the block). No clearing pass.
module ir_thermometer_smbus_read (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    input  logic [7:0]        i_reg_addr,
    input  logic              i_sda_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_scl_out,
    output logic              o_sda_out,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic [15:0]       o_raw_word,
    output logic signed [17:0] o_temp_centi
);
    import irt_pkg::*;

    logic    accept;
    t_result result;

    // take a new beat when the result slot is free or draining
    assign o_in_ready = !o_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    irt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (accept),
        .i_command   (i_command),
        .i_reg_addr  (i_reg_addr),
        .i_sda_in    (i_sda_in),
        .o_result    (result)
    );

    irt_outreg u_outreg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_taken      (i_out_ready),
        .i_result     (result),
        .o_valid      (o_out_valid),
        .o_scl_out    (o_scl_out),
        .o_sda_out    (o_sda_out),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_raw_word   (o_raw_word),
        .o_temp_centi (o_temp_centi)
    );

    // completion beat is never busy and leaves both lines released
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res && o_scl_out && o_sda_out)
        else $error("done beat with busy or lines held");

    // an idle master never pulls a line low
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> o_scl_out && o_sda_out)
        else $error("idle master drives the bus");

    // a stalled result blocks the input side
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted over a stalled result");

    // temperature always tracks the word it is shown with
    a_temp_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_temp_centi == $signed({1'b0, o_raw_word, 1'b0} - TEMP_OFFSET)))
        else $error("temperature does not match raw word");

endmodule

[hdl/irt_seq.sv]
// Bus sequencer: configuration registers, phase/bit/tick state and next-state logic.
// Depends on irt_pkg.
module irt_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_step,
    input  logic            i_command,
    input  logic [7:0]      i_reg_addr,
    input  logic            i_sda_in,
    output irt_pkg::t_result o_result
);
    import irt_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_bit,    n_bit;
    logic [7:0]  r_shift,  n_shift;
    logic [7:0]  r_low,    n_low;
    logic [7:0]  r_target, n_target;
    logic [7:0]  r_tick,   n_tick;
    logic        r_scl,    n_scl;
    logic        r_sda,    n_sda;
    logic [15:0] r_last,   n_last;
    logic [6:0]  r_dev_addr;
    logic [7:0]  r_ticks;

    logic [7:0]  limit;
    logic [8:0]  tick_nx;
    logic [7:0]  addr_w, addr_r;
    logic        rx;
    logic        done;
    t_phase      lo_phase;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= 7'd0;
            r_ticks    <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEV_ADDR: r_dev_addr <= i_cfg_data[6:0];
                CFG_TICKS:    r_ticks    <= i_cfg_data;
                default:      r_dev_addr <= r_dev_addr;
            endcase
        end
    end

    assign limit   = (r_ticks == 8'd0) ? 8'd1 : r_ticks;
    assign tick_nx = {1'b0, r_tick} + 9'd1;
    assign addr_w  = {r_dev_addr, RW_WRITE};
    assign addr_r  = {r_dev_addr, RW_READ};
    assign rx      = (r_phase == PH_RDLOW_HI) || (r_phase == PH_RDHIGH_HI);

    // Low half of the bit slot that belongs to the current high half
    always_comb begin
        case (r_phase)
            PH_WADDR_HI:  lo_phase = PH_WADDR_LO;
            PH_WREG_HI:   lo_phase = PH_WREG_LO;
            PH_RADDR_HI:  lo_phase = PH_RADDR_LO;
            PH_RDLOW_HI:  lo_phase = PH_RDLOW_LO;
            PH_RDHIGH_HI: lo_phase = PH_RDHIGH_LO;
            default:      lo_phase = PH_IDLE;
        endcase
    end

    // Next state for one beat
    always_comb begin
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_low    = r_low;
        n_target = r_target;
        n_tick   = r_tick;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_last   = r_last;
        done     = 1'b0;
        if (i_step) begin
            if (i_command) begin
                // begin is ignored while a transaction runs
                if (r_phase == PH_IDLE) begin
                    n_target = i_reg_addr;
                    n_bit    = 4'd0;
                    n_shift  = 8'd0;
                    n_phase  = PH_START_HI;
                    n_scl    = 1'b1;
                    n_sda    = 1'b1;
                    n_tick   = 8'd0;
                end
            end else if (r_phase != PH_IDLE) begin
                if (tick_nx >= {1'b0, limit}) begin
                    // slot ends: move to the next pin pair
                    n_tick = 8'd0;
                    case (r_phase)
                        PH_START_HI: begin
                            n_phase = PH_START_LO; n_scl = 1'b1; n_sda = 1'b0;
                        end
                        PH_START_LO: begin
                            n_shift = addr_w; n_bit = 4'd0;
                            n_phase = PH_WADDR_LO; n_scl = 1'b0; n_sda = addr_w[7];
                        end
                        PH_RS_LO: begin
                            n_phase = PH_RS_HI; n_scl = 1'b1; n_sda = 1'b1;
                        end
                        PH_RS_HI: begin
                            n_phase = PH_RS_FALL; n_scl = 1'b1; n_sda = 1'b0;
                        end
                        PH_RS_FALL: begin
                            n_shift = addr_r; n_bit = 4'd0;
                            n_phase = PH_RADDR_LO; n_scl = 1'b0; n_sda = addr_r[7];
                        end
                        PH_STOP_LO: begin
                            n_phase = PH_STOP_HI; n_scl = 1'b1; n_sda = 1'b0;
                        end
                        PH_STOP_HI: begin
                            n_phase = PH_STOP_REL; n_scl = 1'b1; n_sda = 1'b1;
                        end
                        PH_STOP_REL: begin
                            n_phase = PH_IDLE; n_scl = 1'b1; n_sda = 1'b1;
                            done    = 1'b1;
                        end
                        // SCL rises, data held
                        PH_WADDR_LO:  begin n_phase = PH_WADDR_HI;  n_scl = 1'b1; end
                        PH_WREG_LO:   begin n_phase = PH_WREG_HI;   n_scl = 1'b1; end
                        PH_RADDR_LO:  begin n_phase = PH_RADDR_HI;  n_scl = 1'b1; end
                        PH_RDLOW_LO:  begin n_phase = PH_RDLOW_HI;  n_scl = 1'b1; end
                        PH_RDHIGH_LO: begin n_phase = PH_RDHIGH_HI; n_scl = 1'b1; end
                        // end of the SCL-high half of a bit
                        PH_WADDR_HI, PH_WREG_HI, PH_RADDR_HI, PH_RDLOW_HI,
                        PH_RDHIGH_HI: begin
                            if (r_bit < BITS_PER_BYTE) begin
                                n_shift = {r_shift[6:0], rx & i_sda_in};
                                n_bit   = r_bit + 4'd1;
                                n_phase = lo_phase;
                                n_scl   = 1'b0;
                                if (r_bit < BITS_PER_BYTE - 4'd1)
                                    n_sda = rx ? 1'b1 : r_shift[6];
                                else
                                    // ack clock: drive low only after the low read byte
                                    n_sda = (r_phase == PH_RDLOW_HI) ? 1'b0 : 1'b1;
                            end else begin
                                n_bit = 4'd0;
                                n_scl = 1'b0;
                                case (r_phase)
                                    PH_WADDR_HI: begin
                                        n_shift = r_target;
                                        n_phase = PH_WREG_LO; n_sda = r_target[7];
                                    end
                                    PH_WREG_HI: begin
                                        n_bit   = r_bit;
                                        n_phase = PH_RS_LO; n_sda = 1'b1;
                                    end
                                    PH_RADDR_HI: begin
                                        n_shift = 8'd0;
                                        n_phase = PH_RDLOW_LO; n_sda = 1'b1;
                                    end
                                    PH_RDLOW_HI: begin
                                        n_low   = r_shift;
                                        n_shift = 8'd0;
                                        n_phase = PH_RDHIGH_LO; n_sda = 1'b1;
                                    end
                                    default: begin
                                        n_bit   = r_bit;
                                        n_last  = {r_shift, r_low};
                                        n_phase = PH_STOP_LO; n_sda = 1'b0;
                                    end
                                endcase
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE; n_scl = 1'b1; n_sda = 1'b1;
                        end
                    endcase
                end else begin
                    n_tick = tick_nx[7:0];
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bit    <= 4'd0;
            r_shift  <= 8'd0;
            r_low    <= 8'd0;
            r_target <= 8'd0;
            r_tick   <= 8'd0;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_last   <= 16'd0;
        end else begin
            r_phase  <= n_phase;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_low    <= n_low;
            r_target <= n_target;
            r_tick   <= n_tick;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
            r_last   <= n_last;
        end
    end

    assign o_result.scl  = n_scl;
    assign o_result.sda  = n_sda;
    assign o_result.busy = (n_phase != PH_IDLE);
    assign o_result.done = done;
    assign o_result.raw  = n_last;

endmodule

[hdl/irt_outreg.sv]
// Result register: holds one result beat, converts the word to centidegrees.
// Depends on irt_pkg.
module irt_outreg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_taken,
    input  irt_pkg::t_result i_result,
    output logic             o_valid,
    output logic             o_scl_out,
    output logic             o_sda_out,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic [15:0]      o_raw_word,
    output logic signed [17:0] o_temp_centi
);
    import irt_pkg::*;

    logic        r_valid;
    t_result     r_result;
    logic [17:0] r_temp;
    logic [17:0] n_temp;

    // raw * 2 - 27315, wraps in 18 bits
    assign n_temp = {1'b0, i_result.raw, 1'b0} - TEMP_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_taken) begin
            r_valid <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
            r_temp   <= n_temp;
        end
    end

    assign o_valid      = r_valid;
    assign o_scl_out    = r_result.scl;
    assign o_sda_out    = r_result.sda;
    assign o_busy_res   = r_result.busy;
    assign o_done_res   = r_result.done;
    assign o_raw_word   = r_result.raw;
    assign o_temp_centi = $signed(r_temp);

endmodule
